// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files, used by hbs_back
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define HBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define HBS_IMPLY(label, pre, post, msg) \
    `HBS_ASSERT(label, (pre) |-> (post), msg)

// next-cycle implication
`define HBS_NEXT(label, pre, post, msg) \
    `HBS_ASSERT(label, (pre) |=> (post), msg)

`endif

// ----- sv/hbs_pkg.sv -----
// types and constants of the hashed bucket set
// no dependencies
`default_nettype none

package hbs_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TOGGLE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [63:0] HASH_MULT = 64'hCBF2_9CE4_8422_2325;
    localparam int CFG_W = 4;
    localparam int BUCKET_INDEX_W = 8;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] value;
    } t_in_item;

    typedef struct packed {
        logic                      was_present;
        logic                      now_present;
        logic [BUCKET_INDEX_W-1:0] bucket_index;
        logic                      status;
    } t_out_item;

endpackage

`default_nettype wire

// ----- sv/hbs_front.sv -----
// front end: accepts items and hashes the value with one shared 32x32 multiplier
// depends on hbs_pkg
`default_nettype none

module hbs_front #(
    parameter int MAX_BUCKET_BITS = 8,
    parameter int HASH_WIDTH      = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire hbs_pkg::t_in_item          i_item,
    input  wire logic [hbs_pkg::CFG_W-1:0]  i_bucket_bits,
    input  wire logic                       i_hold,
    output logic                            o_job_valid,
    input  wire logic                       i_job_full,
    output hbs_pkg::t_cmd                   o_job_cmd,
    output logic [63:0]                     o_job_value,
    output logic [MAX_BUCKET_BITS-1:0]      o_job_bucket
);

    localparam logic [31:0] MULT_LO = hbs_pkg::HASH_MULT[31:0];
    localparam logic [31:0] MULT_HI = hbs_pkg::HASH_MULT[63:32];

    logic          r_busy, n_busy;
    logic [1:0]    r_step, n_step;
    hbs_pkg::t_cmd r_cmd;
    logic [63:0]   r_value;
    logic [63:0]   r_p0;
    logic [31:0]   r_p1, r_p2;

    logic          w_accept;
    logic [31:0]   w_mul_a, w_mul_b;
    logic [63:0]   w_prod;
    logic [31:0]   w_hi;
    logic [15:0]   w_hash;
    logic [16:0]   w_mask;
    logic [15:0]   w_bucket;

    assign full     = r_busy || i_hold;
    assign w_accept = push && !full;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_mul_a = r_value[31:0];
                w_mul_b = MULT_LO;
            end
            2'd1: begin
                w_mul_a = r_value[63:32];
                w_mul_b = MULT_LO;
            end
            2'd2: begin
                w_mul_a = r_value[31:0];
                w_mul_b = MULT_HI;
            end
            2'd3: begin
                w_mul_a = r_value[31:0];
                w_mul_b = MULT_LO;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // only the upper word of the wrapped product feeds the hash
    assign w_hi     = r_p0[63:32] + r_p1 + r_p2;
    assign w_hash   = 16'(w_hi[31 -: HASH_WIDTH]);
    assign w_mask   = (17'd1 << i_bucket_bits) - 17'd1;
    assign w_bucket = w_hash & w_mask[15:0];

    assign o_job_valid  = r_busy && (r_step == 2'd3);
    assign o_job_cmd    = r_cmd;
    assign o_job_value  = r_value;
    assign o_job_bucket = w_bucket[MAX_BUCKET_BITS-1:0];

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_accept) begin
            n_busy = 1'b1;
            n_step = 2'd0;
        end else if (r_busy) begin
            if (r_step != 2'd3) begin
                n_step = r_step + 2'd1;
            end else if (!i_job_full) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_item.command;
            r_value <= i_item.value;
        end
        if (r_busy) begin
            unique case (r_step)
                2'd0: r_p0 <= w_prod;
                2'd1: r_p1 <= w_prod[31:0];
                2'd2: r_p2 <= w_prod[31:0];
                2'd3: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/hbs_queue.sv -----
// two-entry queue between the front end and the bucket engine
// no package dependencies
`default_nettype none

module hbs_queue #(
    parameter int DATA_W = 74
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hbs_back.sv -----
// bucket engine: fill counts, slot memory, search, insert, delete, clear sweep
// depends on hbs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hbs_back #(
    parameter int MAX_BUCKET_BITS  = 8,
    parameter int SLOTS_PER_BUCKET = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_job_valid,
    output logic                            o_job_pop,
    input  wire hbs_pkg::t_cmd              i_job_cmd,
    input  wire logic [63:0]                i_job_value,
    input  wire logic [MAX_BUCKET_BITS-1:0] i_job_bucket,
    output logic                            o_init_busy,
    output logic                            empty,
    input  wire logic                       pop,
    output hbs_pkg::t_out_item              o_result
);

    localparam int BW      = MAX_BUCKET_BITS;
    localparam int BUCKETS = 1 << BW;
    localparam int SLOTS   = SLOTS_PER_BUCKET;
    localparam int FW      = $clog2(SLOTS + 1);
    localparam int AW      = $clog2(BUCKETS * SLOTS);
    localparam logic [FW-1:0] FILL_MAX = FW'(SLOTS);

    typedef enum logic [9:0] {
        S_INIT = 10'b00_0000_0001,
        S_IDLE = 10'b00_0000_0010,
        S_CLR  = 10'b00_0000_0100,
        S_FILL = 10'b00_0000_1000,
        S_SRD  = 10'b00_0001_0000,
        S_SCMP = 10'b00_0010_0000,
        S_ACT  = 10'b00_0100_0000,
        S_SHRD = 10'b00_1000_0000,
        S_SHWR = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    hbs_pkg::t_cmd       r_cmd, n_cmd;
    logic [63:0]         r_value, n_value;
    logic [BW-1:0]       r_bucket, n_bucket;
    logic [BW-1:0]       r_sweep, n_sweep;
    logic [FW-1:0]       r_fill, n_fill;
    logic [FW-1:0]       r_pos, n_pos;
    logic                r_found, n_found;
    logic                r_was, n_was;
    logic                r_now, n_now;
    logic                r_status, n_status;
    logic                r_out_valid;
    hbs_pkg::t_out_item  r_out;

    logic [63:0]         m_slot [BUCKETS*SLOTS];
    logic [FW-1:0]       m_fill [BUCKETS];
    logic [63:0]         r_slot_rdata;
    logic [FW-1:0]       r_fill_rdata;

    logic                w_slot_re, w_slot_we;
    logic [AW-1:0]       w_slot_raddr, w_slot_waddr;
    logic [63:0]         w_slot_wdata;
    logic                w_fill_re, w_fill_we;
    logic [BW-1:0]       w_fill_raddr, w_fill_waddr;
    logic [FW-1:0]       w_fill_wdata;
    logic [AW-1:0]       w_base;
    logic [FW-1:0]       w_pos_inc;
    logic                w_load;
    logic                w_insert;

    assign w_base    = AW'(r_bucket) * AW'(SLOTS);
    assign w_pos_inc = r_pos + FW'(1);
    assign w_insert  = (r_cmd == hbs_pkg::CMD_ADD) || (r_cmd == hbs_pkg::CMD_TOGGLE);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_bucket     = r_bucket;
        n_sweep      = r_sweep;
        n_fill       = r_fill;
        n_pos        = r_pos;
        n_found      = r_found;
        n_was        = r_was;
        n_now        = r_now;
        n_status     = r_status;
        o_job_pop    = 1'b0;
        w_load       = 1'b0;
        w_slot_re    = 1'b0;
        w_slot_raddr = w_base + AW'(r_pos);
        w_slot_we    = 1'b0;
        w_slot_waddr = w_base + AW'(r_pos);
        w_slot_wdata = r_value;
        w_fill_re    = 1'b0;
        w_fill_raddr = i_job_bucket;
        w_fill_we    = 1'b0;
        w_fill_waddr = r_bucket;
        w_fill_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = r_sweep;
                n_sweep      = r_sweep + BW'(1);
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_cmd     = i_job_cmd;
                    n_value   = i_job_value;
                    n_bucket  = i_job_bucket;
                    if (i_job_cmd == hbs_pkg::CMD_CLEAR) begin
                        n_sweep = '0;
                        n_state = S_CLR;
                    end else begin
                        w_fill_re = 1'b1;
                        n_state   = S_FILL;
                    end
                end
            end
            S_CLR: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = r_sweep;
                n_sweep      = r_sweep + BW'(1);
                if (r_sweep == '1) begin
                    n_was    = 1'b0;
                    n_now    = 1'b0;
                    n_status = 1'b0;
                    n_bucket = '0;
                    n_state  = S_DONE;
                end
            end
            S_FILL: begin
                n_fill  = (r_fill_rdata > FILL_MAX) ? FILL_MAX : r_fill_rdata;
                n_pos   = '0;
                n_found = 1'b0;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (r_pos == r_fill) begin
                    n_state = S_ACT;
                end else begin
                    w_slot_re = 1'b1;
                    n_state   = S_SCMP;
                end
            end
            S_SCMP: begin
                if (r_slot_rdata == r_value) begin
                    n_found = 1'b1;
                    n_state = S_ACT;
                end else begin
                    n_pos   = w_pos_inc;
                    n_state = S_SRD;
                end
            end
            S_ACT: begin
                n_was    = r_found;
                n_now    = r_found;
                n_status = 1'b0;
                n_state  = S_DONE;
                if (!r_found && w_insert) begin
                    if (r_fill != FILL_MAX) begin
                        w_slot_we    = 1'b1;
                        w_slot_waddr = w_base + AW'(r_fill);
                        w_fill_we    = 1'b1;
                        w_fill_wdata = r_fill + FW'(1);
                        n_now        = 1'b1;
                    end else begin
                        n_status = 1'b1;
                    end
                end else if (r_found && (r_cmd != hbs_pkg::CMD_ADD)) begin
                    n_now   = 1'b0;
                    n_state = S_SHRD;
                end
            end
            S_SHRD: begin
                if (w_pos_inc < r_fill) begin
                    w_slot_re    = 1'b1;
                    w_slot_raddr = w_base + AW'(w_pos_inc);
                    n_state      = S_SHWR;
                end else begin
                    w_fill_we    = 1'b1;
                    w_fill_wdata = r_fill - FW'(1);
                    n_state      = S_DONE;
                end
            end
            S_SHWR: begin
                w_slot_we    = 1'b1;
                w_slot_wdata = r_slot_rdata;
                n_pos        = w_pos_inc;
                n_state      = S_SHRD;
            end
            S_DONE: begin
                if (!r_out_valid || pop) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_sweep = '0;
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_bucket <= n_bucket;
        r_fill   <= n_fill;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_was    <= n_was;
        r_now    <= n_now;
        r_status <= n_status;
        if (w_load) begin
            r_out.was_present  <= r_was;
            r_out.now_present  <= r_now;
            r_out.bucket_index <= hbs_pkg::BUCKET_INDEX_W'(r_bucket);
            r_out.status       <= r_status;
        end
    end

    // slot store
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            m_slot[w_slot_waddr] <= w_slot_wdata;
        end
        if (w_slot_re) begin
            r_slot_rdata <= m_slot[w_slot_raddr];
        end
    end

    // fill counts
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            m_fill[w_fill_waddr] <= w_fill_wdata;
        end
        if (w_fill_re) begin
            r_fill_rdata <= m_fill[w_fill_raddr];
        end
    end

    assign o_init_busy = (r_state == S_INIT);
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    `HBS_IMPLY(a_fill_bound, w_fill_we, w_fill_wdata <= FILL_MAX, "fill count above slot count")
    `HBS_IMPLY(a_cmp_in_range, r_state == S_SCMP, r_pos < r_fill, "compare beyond bucket fill")
    `HBS_NEXT(a_pop_leads, o_job_pop, (r_state == S_CLR) || (r_state == S_FILL), "bad pop step")
    `HBS_ASSERT(a_load_src, $rose(r_out_valid) |-> $past(r_state == S_DONE), "stray result")

endmodule

`default_nettype wire

// ----- sv/hashed_bucket_set.sv -----
// top level of the hashed bucket set: config register, front end, queue, bucket engine
// depends on hbs_pkg, hbs_front, hbs_queue, hbs_back
//
//   port group     direction  handshake            payload
//   command in     in         push / full          i_item (command, value)
//   result out     out        empty / pop          o_result (was, now, bucket, status)
//   bucket_bits    in         i_cfg_we             i_cfg_wdata
//
// front end: one item at a time, hashed on the shared 32x32 multiplier
// bucket engine: a miss reads every filled slot, a hit stops at the matching slot;
// a removal shifts the later slots down; a clear sweeps every fill count to zero
// after reset the fill counts are swept to zero with full held high
// the queue and result register absorb short stalls; longer ones reach the other side
`default_nettype none

module hashed_bucket_set #(
    parameter int MAX_BUCKET_BITS  = 8,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int HASH_WIDTH       = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire hbs_pkg::t_in_item         i_item,
    output logic                           empty,
    input  wire logic                      pop,
    output hbs_pkg::t_out_item             o_result,
    input  wire logic                      i_cfg_we,
    input  wire logic [hbs_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int BW       = MAX_BUCKET_BITS;
    localparam int JOB_W    = 2 + 64 + BW;
    localparam int LIMIT    = (MAX_BUCKET_BITS > 15) ? 15 : MAX_BUCKET_BITS;
    localparam int RST_BITS = (MAX_BUCKET_BITS < 8) ? MAX_BUCKET_BITS : 8;
    localparam logic [hbs_pkg::CFG_W-1:0] BITS_LIMIT = hbs_pkg::CFG_W'(LIMIT);
    localparam logic [hbs_pkg::CFG_W-1:0] BITS_RESET = hbs_pkg::CFG_W'(RST_BITS);

    logic [hbs_pkg::CFG_W-1:0] r_bucket_bits, n_bucket_bits;

    logic                      w_init_busy;
    logic                      w_front_valid;
    hbs_pkg::t_cmd             w_front_cmd;
    logic [63:0]               w_front_value;
    logic [BW-1:0]             w_front_bucket;
    logic                      w_q_full, w_q_empty, w_q_pop;
    logic [JOB_W-1:0]          w_q_in, w_q_out;

    assign n_bucket_bits = (i_cfg_wdata > BITS_LIMIT) ? BITS_LIMIT : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= BITS_RESET;
        end else if (i_cfg_we) begin
            r_bucket_bits <= n_bucket_bits;
        end
    end

    hbs_front #(
        .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
        .HASH_WIDTH      (HASH_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (i_item),
        .i_bucket_bits (r_bucket_bits),
        .i_hold        (w_init_busy),
        .o_job_valid   (w_front_valid),
        .i_job_full    (w_q_full),
        .o_job_cmd     (w_front_cmd),
        .o_job_value   (w_front_value),
        .o_job_bucket  (w_front_bucket)
    );

    assign w_q_in = {w_front_cmd, w_front_value, w_front_bucket};

    hbs_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    hbs_back #(
        .MAX_BUCKET_BITS  (MAX_BUCKET_BITS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!w_q_empty),
        .o_job_pop    (w_q_pop),
        .i_job_cmd    (hbs_pkg::t_cmd'(w_q_out[JOB_W-1 -: 2])),
        .i_job_value  (w_q_out[BW +: 64]),
        .i_job_bucket (w_q_out[BW-1:0]),
        .o_init_busy  (w_init_busy),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for hashed_bucket_set: directed table then random command streams per bucket width
// keeps its own copy of the buckets; checks each result against it or the directed table
// depends on hbs_pkg and hashed_bucket_set
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BITS    = 8;
    localparam int SLOTS       = 4;
    localparam int HASH_W      = 16;
    localparam int BUCKETS     = 1 << MAX_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 141;
    localparam int POOL_SIZE   = 16;

    typedef struct packed {
        bit                 is_cfg;
        logic [3:0]         cfg_val;
        hbs_pkg::t_cmd      cmd;
        logic [63:0]        val;
        bit                 typed;
        hbs_pkg::t_out_item want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    hbs_pkg::t_in_item i_item = '0;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [hbs_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic        full;
    logic        empty;
    hbs_pkg::t_out_item o_result;

    logic        gaps_on = 1'b1;

    // own copy of the set
    logic [63:0] slot_mem [BUCKETS][SLOTS];
    logic [2:0]  fill_cnt [BUCKETS];
    logic [3:0]  bits_model;

    hbs_pkg::t_out_item pending_results [$];
    t_stim_row   directed_rows [$];
    logic [63:0] value_pool [POOL_SIZE];

    int errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_clear = 0;
    int n_settings = 0;
    int stall_cycles = 0;

    hashed_bucket_set #(
        .MAX_BUCKET_BITS (MAX_BITS),
        .SLOTS_PER_BUCKET(SLOTS),
        .HASH_WIDTH      (HASH_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] bucket_of(input logic [63:0] v, input logic [3:0] bits);
        logic [63:0] prod;
        logic [15:0] mask;
        prod = v * hbs_pkg::HASH_MULT;
        mask = (16'd1 << bits) - 16'd1;
        return prod[55:48] & mask[7:0];
    endfunction

    function automatic hbs_pkg::t_out_item apply_command(input hbs_pkg::t_cmd c,
                                                         input logic [63:0] v);
        hbs_pkg::t_out_item r;
        logic [7:0] b;
        int n;
        int pos;
        bit found;
        r = '0;
        if (c == hbs_pkg::CMD_CLEAR) begin
            foreach (fill_cnt[k]) fill_cnt[k] = '0;
            n_clear++;
            return r;
        end
        b = bucket_of(v, bits_model);
        n = int'(fill_cnt[b]);
        found = 1'b0;
        pos = 0;
        for (int k = 0; k < n; k++) begin
            if (!found && slot_mem[b][k] == v) begin
                found = 1'b1;
                pos = k;
            end
        end
        r.was_present = found;
        r.bucket_index = b;
        if (!found && c != hbs_pkg::CMD_DELETE) begin
            if (n < SLOTS) begin
                slot_mem[b][n] = v;
                fill_cnt[b] = 3'(n + 1);
                r.now_present = 1'b1;
            end else begin
                r.status = 1'b1;
                n_full++;
            end
        end else if (found && c != hbs_pkg::CMD_ADD) begin
            for (int k = pos; k + 1 < n; k++) slot_mem[b][k] = slot_mem[b][k + 1];
            fill_cnt[b] = 3'(n - 1);
        end else begin
            r.now_present = found;
        end
        return r;
    endfunction

    function automatic hbs_pkg::t_out_item res(input bit was, input bit now,
                                               input logic [7:0] bkt, input bit st);
        return {was, now, bkt, st};
    endfunction

    function automatic t_stim_row op(input hbs_pkg::t_cmd c, input logic [63:0] v);
        return {1'b0, 4'd0, c, v, 1'b0, 11'd0};
    endfunction

    function automatic t_stim_row op_t(input hbs_pkg::t_cmd c, input logic [63:0] v,
                                       input hbs_pkg::t_out_item w);
        return {1'b0, 4'd0, c, v, 1'b1, w};
    endfunction

    function automatic t_stim_row cfg_row(input logic [3:0] v);
        return {1'b1, v, hbs_pkg::CMD_ADD, 64'd0, 1'b0, 11'd0};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 100)
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    task automatic send(input hbs_pkg::t_cmd c, input logic [63:0] v, input bit typed,
                        input hbs_pkg::t_out_item w);
        hbs_pkg::t_out_item pred;
        while (gaps_on && $urandom_range(99) < 27) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= {c, v};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pred = apply_command(c, v);
        pending_results.push_back(typed ? w : pred);
        n_items++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_bucket_bits(input logic [3:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bits_model = (v > MAX_BITS) ? 4'(MAX_BITS) : v;
        n_settings++;
    endtask

    // values steered into a few buckets so that buckets fill up and overflow
    task automatic build_pool();
        logic [7:0] targets [3];
        logic [15:0] mask;
        logic [63:0] v;
        mask = (16'd1 << bits_model) - 16'd1;
        foreach (targets[t]) targets[t] = 8'($urandom_range(255)) & mask[7:0];
        foreach (value_pool[p]) begin
            v = {$urandom, $urandom};
            for (int k = 0; k < 4000 && bucket_of(v, bits_model) != targets[p % 3]; k++)
                v = {$urandom, $urandom};
            value_pool[p] = v;
        end
    endtask

    // pop side
    always @(posedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= gaps_on ? ($urandom_range(99) >= 27) : 1'b1;
    end

    always @(posedge i_clk) begin
        hbs_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(o_result), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.was_present !== want.was_present)
                    report_mismatch("was_present", 64'(o_result.was_present),
                                    64'(want.was_present));
                if (o_result.now_present !== want.now_present)
                    report_mismatch("now_present", 64'(o_result.now_present),
                                    64'(want.now_present));
                if (o_result.bucket_index !== want.bucket_index)
                    report_mismatch("bucket_index", 64'(o_result.bucket_index),
                                    64'(want.bucket_index));
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(o_result.status), 64'(want.status));
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0] widths [8];
        t_stim_row row;
        hbs_pkg::t_cmd c;
        logic [63:0] v;
        int w;

        widths = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd9, 4'd2, 4'd5};
        foreach (fill_cnt[k]) fill_cnt[k] = '0;
        foreach (slot_mem[k, s]) slot_mem[k][s] = '0;
        bits_model = 4'(MAX_BITS);

        // reset width, then saturated width, then a single bucket
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd0,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd0,
                                     res(1'b1, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_TOGGLE, 64'd0,
                                     res(1'b1, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_TOGGLE, 64'd0,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_DELETE, 64'd0,
                                     res(1'b1, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_DELETE, 64'd0,
                                     res(1'b0, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op(hbs_pkg::CMD_ADD, '1));
        directed_rows.push_back(op(hbs_pkg::CMD_ADD, 64'h8000_0000_0000_0000));
        directed_rows.push_back(op_t(hbs_pkg::CMD_CLEAR, '1,
                                     res(1'b0, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op(hbs_pkg::CMD_DELETE, '1));
        directed_rows.push_back(cfg_row(4'd15));
        directed_rows.push_back(op(hbs_pkg::CMD_ADD, 64'd1));
        directed_rows.push_back(cfg_row(4'd0));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd1,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd2,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd3,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd4,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd5,
                                     res(1'b0, 1'b0, 8'd0, 1'b1)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_TOGGLE, 64'd6,
                                     res(1'b0, 1'b0, 8'd0, 1'b1)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_DELETE, 64'd5,
                                     res(1'b0, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_DELETE, 64'd2,
                                     res(1'b1, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_TOGGLE, 64'd5,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd4,
                                     res(1'b1, 1'b1, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_DELETE, 64'd1,
                                     res(1'b1, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_CLEAR,  64'd0,
                                     res(1'b0, 1'b0, 8'd0, 1'b0)));
        directed_rows.push_back(op_t(hbs_pkg::CMD_ADD,    64'd3,
                                     res(1'b0, 1'b1, 8'd0, 1'b0)));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.is_cfg) write_bucket_bits(row.cfg_val);
            else send(row.cmd, row.val, row.typed, row.want);
        end

        foreach (widths[p]) begin
            write_bucket_bits(widths[p]);
            gaps_on <= (p != 3);
            build_pool();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                w = $urandom_range(99);
                if (w < 2) begin
                    c = hbs_pkg::CMD_CLEAR;
                    v = {$urandom, $urandom};
                end else if (w < 27) begin
                    c = hbs_pkg::t_cmd'($urandom_range(2));
                    v = {$urandom, $urandom};
                end else begin
                    w = $urandom_range(99);
                    c = (w < 40) ? hbs_pkg::CMD_ADD :
                        (w < 75) ? hbs_pkg::CMD_TOGGLE : hbs_pkg::CMD_DELETE;
                    v = value_pool[$urandom_range(POOL_SIZE - 1)];
                end
                send(c, v, 1'b0, '0);
            end
        end

        drain();
        gaps_on <= 1'b1;
        repeat (400) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("items never returned", 64'(pending_results.size()), 64'd0);

        $display("%0d commands over %0d bucket widths, %0d results checked", n_items,
                 n_settings, n_checked);
        $display("%0d inserts refused on a full bucket, %0d clears", n_full, n_clear);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
